// ===== rtl/spbh_pkg.sv =====
package spbh_pkg;

   localparam int LEN_BITS_DEF   = 24;
   localparam int TAIL_DEPTH_DEF = 32;

   localparam int BLOCK_LEN = 12;
   localparam int BLOCK_MIN = 32;

   localparam int ROT_A    = 14;
   localparam int ROT_B    = 11;
   localparam int ROT_H    = 25;
   localparam int FOLD_SHL = 5;
   localparam int FOLD_SHR = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_MIX_A,
      ST_MIX_B,
      ST_MIX_H,
      ST_FOLD_START,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      ALU_PASS,
      ALU_MIX_A,
      ALU_MIX_B,
      ALU_MIX_H,
      ALU_FOLD
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] fold_byte;
   } alu_ctl_type;

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int s);
      return (x >> s) | (x << (32 - s));
   endfunction

endpackage

// ===== rtl/spbh_ram.sv =====
module spbh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spbh_alu.sv =====
module spbh_alu (
   input  spbh_pkg::alu_ctl_type ctl,
   input  logic [31:0]           opnd_x,
   input  logic [31:0]           opnd_y,
   output logic [31:0]           result
);
   import spbh_pkg::*;

   always_comb begin
      unique case (ctl.op)
         ALU_MIX_A: result = (opnd_x ^ opnd_y) - rotr32(opnd_y, ROT_A);
         ALU_MIX_B: result = (opnd_x ^ opnd_y) - rotr32(opnd_y, ROT_B);
         ALU_MIX_H: result = (opnd_x ^ opnd_y) - rotr32(opnd_y, ROT_H);
         ALU_FOLD:  result = opnd_x ^ ((opnd_x << FOLD_SHL) + (opnd_x >> FOLD_SHR)
                                       + {24'd0, ctl.fold_byte});
         default:   result = opnd_x;
      endcase
   end

endmodule

// ===== rtl/string_prefix_block_hash.sv =====
// Byte-serial string hash. Each beat on the req_ channel carries one byte of
// a string together with the string's total length; req_first_of_string marks
// the first beat of a string, and a new start abandons any string in progress.
// Exactly one beat leaves on the rsp_ channel per finished string: the 32-bit hash
// after the last byte, or zero at once for a string of length zero.
// Bytes are taken one per cycle while the block is idle and the output register
// is free. Each completed 12-byte block then takes an add step and three mix
// steps through the shared unit, during which req_ready is low. After the last
// byte the buffered tail of n bytes (n at most 31) is folded from last to first,
// one byte per cycle through the same unit, reading the tail buffer RAM; the
// result then passes through ST_FOLD_START, ST_FOLD and ST_EMIT before it is
// registered. A zero-length string gives its result in the following cycle.
// The result sits in an output register; while it waits to be taken, further
// bytes are not accepted, and a finished hash waits in its own state until the
// output register is free.
// Reset is synchronous and returns the block to idle with no string in
// progress and no result pending. The tail buffer needs no clearing.
module string_prefix_block_hash #(
   parameter int LEN_BITS   = spbh_pkg::LEN_BITS_DEF,
   parameter int TAIL_DEPTH = spbh_pkg::TAIL_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic [LEN_BITS-1:0] req_string_length,
   input  logic                req_first_of_string,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_hash_value
);
   import spbh_pkg::*;

   localparam int TAIL_AW  = $clog2(TAIL_DEPTH);
   localparam int BLK_BITS = BLOCK_LEN * 8;

   state_type state_ff, state_in;

   logic [31:0]         mix_a_ff, mix_a_in;
   logic [31:0]         mix_b_ff, mix_b_in;
   logic [31:0]         mix_h_ff, mix_h_in;
   logic [LEN_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [BLK_BITS-1:0] block_ff, block_in;
   logic [3:0]          block_fill_ff, block_fill_in;
   logic [TAIL_AW-1:0]  tail_fill_ff, tail_fill_in;
   logic [TAIL_AW-1:0]  fold_cnt_ff, fold_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_hash_ff, rsp_hash_in;

   logic                accept;
   logic                slot_free;
   logic                start;
   logic                zero_len;
   logic                to_block;
   logic                blk_full;
   logic                str_end;
   logic [LEN_BITS-1:0] eff_left;
   logic [LEN_BITS-1:0] left_next;
   logic [3:0]          eff_blk;
   logic [3:0]          blk_next;
   logic [TAIL_AW-1:0]  eff_tail;
   logic [TAIL_AW-1:0]  tail_next;
   logic [TAIL_AW-1:0]  tail_after;

   logic                ram_wr_en;
   logic [TAIL_AW-1:0]  ram_rd_addr;
   logic [7:0]          ram_rd_data;

   alu_ctl_type         alu_ctl;
   logic [31:0]         alu_x;
   logic [31:0]         alu_y;
   logic [31:0]         alu_result;

   spbh_ram #(
      .WIDTH (8),
      .DEPTH (TAIL_DEPTH)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (eff_tail),
      .wr_data (req_data_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   spbh_alu u_alu (
      .ctl    (alu_ctl),
      .opnd_x (alu_x),
      .opnd_y (alu_y),
      .result (alu_result)
   );

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_valid && req_ready;
   assign start      = req_first_of_string || (bytes_left_ff == '0);
   assign eff_left   = start ? req_string_length : bytes_left_ff;
   assign eff_blk    = start ? 4'd0 : block_fill_ff;
   assign eff_tail   = start ? '0 : tail_fill_ff;
   assign zero_len   = start && (req_string_length == '0);
   assign to_block   = (eff_blk != 4'd0) || (eff_left >= LEN_BITS'(BLOCK_MIN));
   assign left_next  = eff_left - LEN_BITS'(1);
   assign blk_next   = eff_blk + 4'd1;
   assign tail_next  = eff_tail + TAIL_AW'(1);
   assign blk_full   = to_block && (blk_next == 4'(BLOCK_LEN));
   assign str_end    = !zero_len && (left_next == '0);
   assign tail_after = to_block ? eff_tail : tail_next;
   assign ram_wr_en  = accept && !zero_len && !to_block;
   assign ram_rd_addr = (state_ff == ST_FOLD) ? fold_cnt_ff - TAIL_AW'(2)
                                              : fold_cnt_ff - TAIL_AW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !zero_len) begin
               if (blk_full) begin
                  state_in = ST_ADD;
               end else if (str_end) begin
                  state_in = (tail_after == '0) ? ST_EMIT : ST_FOLD_START;
               end
            end
         end
         ST_ADD:        state_in = ST_MIX_A;
         ST_MIX_A:      state_in = ST_MIX_B;
         ST_MIX_B:      state_in = ST_MIX_H;
         ST_MIX_H:      state_in = ST_IDLE;
         ST_FOLD_START: state_in = ST_FOLD;
         ST_FOLD: begin
            if (fold_cnt_ff == TAIL_AW'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mix_a_in      = mix_a_ff;
      mix_b_in      = mix_b_ff;
      mix_h_in      = mix_h_ff;
      bytes_left_in = bytes_left_ff;
      block_in      = block_ff;
      block_fill_in = block_fill_ff;
      tail_fill_in  = tail_fill_ff;
      fold_cnt_in   = fold_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_hash_in   = rsp_hash_ff;
      alu_ctl.op        = ALU_PASS;
      alu_ctl.fold_byte = ram_rd_data;
      alu_x         = mix_h_ff;
      alu_y         = mix_b_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (start) begin
                  mix_a_in      = '0;
                  mix_b_in      = '0;
                  mix_h_in      = 32'(req_string_length);
                  bytes_left_in = req_string_length;
                  block_fill_in = 4'd0;
                  tail_fill_in  = '0;
               end
               if (zero_len) begin
                  rsp_valid_in = 1'b1;
                  rsp_hash_in  = '0;
               end else begin
                  if (to_block) begin
                     for (int k = 0; k < BLOCK_LEN; k++) begin
                        if (eff_blk == 4'(k)) begin
                           block_in[8*k +: 8] = req_data_byte;
                        end
                     end
                     block_fill_in = blk_full ? 4'd0 : blk_next;
                  end else begin
                     tail_fill_in = tail_next;
                  end
                  bytes_left_in = left_next;
                  if (str_end) begin
                     fold_cnt_in   = tail_after;
                     tail_fill_in  = '0;
                     block_fill_in = 4'd0;
                  end
               end
            end
         end
         ST_ADD: begin
            mix_a_in = mix_a_ff + block_ff[31:0];
            mix_b_in = mix_b_ff + block_ff[63:32];
            mix_h_in = mix_h_ff + block_ff[95:64];
         end
         ST_MIX_A: begin
            alu_ctl.op = ALU_MIX_A;
            alu_x      = mix_a_ff;
            alu_y      = mix_h_ff;
            mix_a_in   = alu_result;
         end
         ST_MIX_B: begin
            alu_ctl.op = ALU_MIX_B;
            alu_x      = mix_b_ff;
            alu_y      = mix_a_ff;
            mix_b_in   = alu_result;
         end
         ST_MIX_H: begin
            alu_ctl.op = ALU_MIX_H;
            alu_x      = mix_h_ff;
            alu_y      = mix_b_ff;
            mix_h_in   = alu_result;
         end
         ST_FOLD_START: begin
         end
         ST_FOLD: begin
            alu_ctl.op  = ALU_FOLD;
            alu_x       = mix_h_ff;
            mix_h_in    = alu_result;
            fold_cnt_in = fold_cnt_ff - TAIL_AW'(1);
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = mix_h_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bytes_left_ff <= '0;
         block_fill_ff <= '0;
         tail_fill_ff  <= '0;
         fold_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bytes_left_ff <= bytes_left_in;
         block_fill_ff <= block_fill_in;
         tail_fill_ff  <= tail_fill_in;
         fold_cnt_ff   <= fold_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_a_ff    <= mix_a_in;
      mix_b_ff    <= mix_b_in;
      mix_h_ff    <= mix_h_in;
      block_ff    <= block_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   a_zero_len_result: assert property (@(posedge clock) disable iff (reset)
      accept && zero_len |=> rsp_valid && (rsp_hash_value == '0))
      else $error("zero-length string did not give a zero result");

   a_add_after_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (block_fill_ff == 4'd0))
      else $error("block count not cleared on a full block");

   a_fold_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (fold_cnt_ff != '0))
      else $error("tail fold running with nothing left to fold");

endmodule
